>>> src/msort_pkg.sv
// Shared constants and types of the merge sorter.
package msort_pkg;

  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = CNT_W + 2;

  // Buffer port request from the merge engine.
  typedef struct packed {
    logic [IDX_W-1:0]  rd_addr_a;
    logic [IDX_W-1:0]  rd_addr_b;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_bank;
  } msort_mreq_t;

endpackage

>>> src/merge_sorter_unit.sv
// Batch sorter: loads values, merge-sorts them in two buffer banks, streams them out.
// Load: takes one input transaction per cycle; the block is ready only while loading.
// Sort: each merge step is a read state, then a compare-and-write state; each run
//   starts in a setup state, which also signals when the sort is finished.
// Emit: each result is a buffer read, then shown until the output side accepts it.
// Reset clears the element count, the overflow flag and all sequencer state;
//   buffer contents are undefined until written.
module merge_sorter_unit import msort_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic                     last_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] sorted_value_o,
  output logic                     last_out_o,
  output logic                     overflow_o
);

  // Top-level phases: collect the batch, sort it, then fetch and show each result.
  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_SORT  = 4'b0010,
    ST_FETCH = 4'b0100,
    ST_SHOW  = 4'b1000
  } top_state_e;

  top_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             ovf_q, ovf_d;
  logic [IDX_W-1:0] idx_q, idx_d;

  logic              in_fire, out_fire, load_we, has_room, merge_done, is_last;
  msort_mreq_t       mreq;
  logic              b0_we, b1_we;
  logic [IDX_W-1:0]  b0_waddr, b0_raddr_a, b0_raddr_b, b1_raddr_a, b1_raddr_b;
  logic [DATA_W-1:0] b0_wdata, b0_rd_a, b0_rd_b, b1_rd_a, b1_rd_b;
  logic [DATA_W-1:0] src_rd_a, src_rd_b;

  assign in_ready_o  = (state_q == ST_LOAD);
  assign out_valid_o = (state_q == ST_SHOW);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_o && out_ready_i;

  // Store while there is room; drop the value otherwise but still honor last.
  assign has_room = (cnt_q < CNT_W'(DEPTH));
  assign load_we  = in_fire && has_room;

  assign is_last = ((CNT_W'(idx_q) + CNT_W'(1)) == cnt_q);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ovf_d   = ovf_q;
    idx_d   = idx_q;
    case (state_q)
      ST_LOAD: begin
        if (in_fire) begin
          if (has_room) begin
            cnt_d = cnt_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (last_i) begin
            state_d = ST_SORT;
          end
        end
      end
      ST_SORT: begin
        if (merge_done) begin
          idx_d   = '0;
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_d = ST_SHOW;
      end
      ST_SHOW: begin
        if (out_fire) begin
          if (is_last) begin
            // Batch delivered: return to empty.
            cnt_d   = '0;
            ovf_d   = 1'b0;
            state_d = ST_LOAD;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = ST_FETCH;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      idx_q   <= idx_d;
    end
  end

  // The merge engine reads the count only after the final store has settled.
  msort_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_fire && last_i),
    .count_i     (cnt_q),
    .rd_data_a_i (src_rd_a),
    .rd_data_b_i (src_rd_b),
    .mreq_o      (mreq),
    .done_o      (merge_done)
  );

  // Bank steering: loading fills bank 0, each merge pass writes the bank it
  // does not read, and the emit phase reads the bank left by the last pass.
  assign b0_we    = load_we || (mreq.wr_en && mreq.rd_bank);
  assign b1_we    = mreq.wr_en && !mreq.rd_bank;
  assign b0_waddr = load_we ? cnt_q[IDX_W-1:0] : mreq.wr_addr;
  assign b0_wdata = load_we ? value_i : mreq.wr_data;

  assign b0_raddr_a = (state_q == ST_SORT) ? mreq.rd_addr_a : idx_q;
  assign b1_raddr_a = (state_q == ST_SORT) ? mreq.rd_addr_a : idx_q;
  assign b0_raddr_b = mreq.rd_addr_b;
  assign b1_raddr_b = mreq.rd_addr_b;

  msort_ram #(.WIDTH(DATA_W), .ADDR_W(IDX_W)) u_bank0 (
    .clk_i     (clk_i),
    .we_i      (b0_we),
    .waddr_i   (b0_waddr),
    .wdata_i   (b0_wdata),
    .raddr_a_i (b0_raddr_a),
    .raddr_b_i (b0_raddr_b),
    .rdata_a_o (b0_rd_a),
    .rdata_b_o (b0_rd_b)
  );

  msort_ram #(.WIDTH(DATA_W), .ADDR_W(IDX_W)) u_bank1 (
    .clk_i     (clk_i),
    .we_i      (b1_we),
    .waddr_i   (mreq.wr_addr),
    .wdata_i   (mreq.wr_data),
    .raddr_a_i (b1_raddr_a),
    .raddr_b_i (b1_raddr_b),
    .rdata_a_o (b1_rd_a),
    .rdata_b_o (b1_rd_b)
  );

  assign src_rd_a = mreq.rd_bank ? b1_rd_a : b0_rd_a;
  assign src_rd_b = mreq.rd_bank ? b1_rd_b : b0_rd_b;

  // Hold the address while showing, so the registered read data stays put.
  assign sorted_value_o = $signed(src_rd_a);
  assign last_out_o     = is_last;
  assign overflow_o     = ovf_q;

`ifndef SYNTHESIS
  a_one_side_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output sides active together");

  a_last_starts_sort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && last_i) |=> (state_q == ST_SORT))
    else $error("last transaction did not start the sort");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("element count above buffer depth");

  a_run_end_reloads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && last_out_o) |=> (in_ready_o && (cnt_q == '0) && !ovf_q))
    else $error("block not empty after final result");
`endif

endmodule

>>> src/msort_ram.sv
// Buffer bank: one write port, two registered read ports.
module msort_ram #(
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_a_i,
  input  logic [ADDR_W-1:0] raddr_b_i,
  output logic [WIDTH-1:0]  rdata_a_o,
  output logic [WIDTH-1:0]  rdata_b_o
);

  logic [WIDTH-1:0] mem_q [2**ADDR_W];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

>>> src/msort_merge.sv
// Bottom-up merge sequencer with one shared signed comparator.
module msort_merge import msort_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [CNT_W-1:0]  count_i,
  input  logic [DATA_W-1:0] rd_data_a_i,
  input  logic [DATA_W-1:0] rd_data_b_i,
  output msort_mreq_t       mreq_o,
  output logic              done_o
);

  typedef enum logic [3:0] {
    M_IDLE = 4'b0001,
    M_RUN  = 4'b0010,
    M_READ = 4'b0100,
    M_CMP  = 4'b1000
  } merge_state_e;

  merge_state_e state_q, state_d;
  logic [SUM_W-1:0] w_q, w_d;
  logic [CNT_W-1:0] lo_q, lo_d, mid_q, mid_d, hi_q, hi_d;
  logic [CNT_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic             bank_q, bank_d;

  logic [SUM_W-1:0] n_ext, w_dbl, mid_sum, hi_sum;
  logic [CNT_W-1:0] mid_clip, hi_clip, k_inc;
  logic             take_a;

  assign n_ext    = SUM_W'(count_i);
  assign w_dbl    = w_q << 1;
  assign mid_sum  = SUM_W'(lo_q) + w_q;
  assign hi_sum   = SUM_W'(lo_q) + w_dbl;
  assign mid_clip = (mid_sum > n_ext) ? count_i : mid_sum[CNT_W-1:0];
  assign hi_clip  = (hi_sum > n_ext) ? count_i : hi_sum[CNT_W-1:0];
  assign k_inc    = k_q + CNT_W'(1);

  // Take the left element on ties to keep the sort stable.
  assign take_a = (i_q < mid_q) &&
                  ((j_q >= hi_q) || ($signed(rd_data_a_i) <= $signed(rd_data_b_i)));

  always_comb begin
    state_d = state_q;
    w_d     = w_q;
    lo_d    = lo_q;
    mid_d   = mid_q;
    hi_d    = hi_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    bank_d  = bank_q;
    done_o  = 1'b0;
    case (state_q)
      M_IDLE: begin
        if (start_i) begin
          w_d     = SUM_W'(1);
          lo_d    = '0;
          bank_d  = 1'b0;
          state_d = M_RUN;
        end
      end
      M_RUN: begin
        if (w_q >= n_ext) begin
          done_o  = 1'b1;
          state_d = M_IDLE;
        end else begin
          mid_d   = mid_clip;
          hi_d    = hi_clip;
          i_d     = lo_q;
          j_d     = mid_clip;
          k_d     = lo_q;
          state_d = M_READ;
        end
      end
      M_READ: begin
        state_d = M_CMP;
      end
      M_CMP: begin
        if (take_a) begin
          i_d = i_q + CNT_W'(1);
        end else begin
          j_d = j_q + CNT_W'(1);
        end
        k_d = k_inc;
        if (k_inc == hi_q) begin
          if (hi_sum >= n_ext) begin
            // Pass complete: swap banks and double the run width.
            w_d    = w_dbl;
            lo_d   = '0;
            bank_d = ~bank_q;
          end else begin
            lo_d = hi_sum[CNT_W-1:0];
          end
          state_d = M_RUN;
        end else begin
          state_d = M_READ;
        end
      end
      default: begin
        state_d = M_IDLE;
      end
    endcase
  end

  always_comb begin
    mreq_o.rd_addr_a = i_q[IDX_W-1:0];
    mreq_o.rd_addr_b = j_q[IDX_W-1:0];
    mreq_o.wr_en     = (state_q == M_CMP);
    mreq_o.wr_addr   = k_q[IDX_W-1:0];
    mreq_o.wr_data   = take_a ? rd_data_a_i : rd_data_b_i;
    mreq_o.rd_bank   = bank_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      w_q     <= '0;
      lo_q    <= '0;
      mid_q   <= '0;
      hi_q    <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      bank_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      w_q     <= w_d;
      lo_q    <= lo_d;
      mid_q   <= mid_d;
      hi_q    <= hi_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      bank_q  <= bank_d;
    end
  end

endmodule

>>> tb/tb_merge_sorter_unit.sv
// Self-checking testbench for the merge sorter: random batches, stalls and a sorting scoreboard.
`timescale 1ns / 100ps

module tb_merge_sorter_unit import msort_pkg::*; ();

  // Cycles without any transaction on either channel before the run is declared hung.
  // The slowest legal quiet stretch is a full 64-entry sort plus the long receiver
  // hold-off, so this leaves a wide margin.
  localparam int unsigned STALL_LIMIT  = 20000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned IDLE_PCT     = 37;
  localparam int unsigned TOTAL_ITEMS  = 120;

  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic                     ovf;
  } sorted_item_t;

  // Scoreboard: mirrors the batch buffer, sorts it on the closing item and queues the
  // sorted run; every result transaction is compared against the oldest queued entry.
  class sort_scoreboard;
    logic signed [DATA_W-1:0] run_buf[DEPTH];
    logic signed [DATA_W-1:0] merge_buf[DEPTH];
    int unsigned              held_cnt;
    bit                       dropped;
    sorted_item_t             want_q[$];
    int unsigned              mismatches;
    int unsigned              results_checked;

    function new();
      held_cnt        = 0;
      dropped         = 1'b0;
      mismatches      = 0;
      results_checked = 0;
    endfunction

    function int unsigned pending();
      return want_q.size();
    endfunction

    // Stable bottom-up merge; ties take the element from the left run.
    function void merge_sort(int unsigned n);
      int unsigned span, lo, mid, hi, i, j, k;
      for (span = 1; span < n; span = span * 2) begin
        for (lo = 0; lo < n; lo = lo + 2 * span) begin
          mid = (lo + span > n) ? n : lo + span;
          hi  = (lo + 2 * span > n) ? n : lo + 2 * span;
          i = lo;
          j = mid;
          k = lo;
          while (i < mid || j < hi) begin
            if (j >= hi || (i < mid && run_buf[i] <= run_buf[j])) begin
              merge_buf[k] = run_buf[i];
              i++;
            end else begin
              merge_buf[k] = run_buf[j];
              j++;
            end
            k++;
          end
        end
        for (k = 0; k < n; k++) run_buf[k] = merge_buf[k];
      end
    endfunction

    function void note_input(logic signed [DATA_W-1:0] v, logic lst);
      sorted_item_t item;
      if (held_cnt < DEPTH) begin
        run_buf[held_cnt] = v;
        held_cnt++;
      end else begin
        dropped = 1'b1;
      end
      if (lst) begin
        merge_sort(held_cnt);
        for (int k = 0; k < held_cnt; k++) begin
          item.value = run_buf[k];
          item.last  = (k + 1 == held_cnt);
          item.ovf   = dropped;
          want_q.push_back(item);
        end
        held_cnt = 0;
        dropped  = 1'b0;
      end
    endfunction

    function void check_result(logic signed [DATA_W-1:0] v, logic lst, logic ovf);
      sorted_item_t want;
      results_checked++;
      if (want_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: value=%0d last=%b overflow=%b",
                   $realtime, v, lst, ovf);
        return;
      end
      want = want_q.pop_front();
      if (v !== want.value || lst !== want.last || ovf !== want.ovf) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result %0d: expected value=%0d last=%b overflow=%b,",
                   $realtime, results_checked, want.value, want.last, want.ovf,
                   " got value=%0d last=%b overflow=%b", v, lst, ovf);
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic signed [DATA_W-1:0] value;
  logic                     last;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [DATA_W-1:0] sorted_value;
  logic                     last_out;
  logic                     overflow;

  sort_scoreboard sorter = new();
  int unsigned    items_sent = 0;

  always #10 clk = ~clk;

  merge_sorter_unit dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .value_i        (value),
    .last_i         (last),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .sorted_value_o (sorted_value),
    .last_out_o     (last_out),
    .overflow_o     (overflow)
  );

  // Offer one input transaction and hold it until the block takes it. Insert a random
  // gap first, except inside a steady window where the sender offers back to back.
  task automatic send_item(input logic signed [DATA_W-1:0] v, input logic lst);
    bit steady;
    steady = (items_sent >= 40 && items_sent < 90);
    if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    last     <= lst;
    do @(posedge clk); while (!in_ready);
    sorter.note_input(v, lst);
    items_sent++;
  endtask

  task automatic send_batch(input logic signed [DATA_W-1:0] vals[$]);
    foreach (vals[k]) send_item(vals[k], k == vals.size() - 1);
  endtask

  // Mix extremes, a narrow band that forces ties, and full-range values.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2, 3:    return int'($urandom_range(0, 15)) - 8;
      default: return $urandom;
    endcase
  endfunction

  // Stimulus: reset, a directed set of batches, then random batches.
  initial begin
    int unsigned batch_idx, len;
    logic signed [DATA_W-1:0] batch[$];
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    value    <= '0;
    last     <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single-element batches at both extremes, then a mixed batch of extremes, zero and +-1.
    send_batch('{VAL_MAX});
    send_batch('{VAL_MIN});
    send_batch('{32'sd0, -32'sd1, VAL_MAX, VAL_MIN, 32'sd1});
    // Repeated keys stress the tie rule; a descending batch forces every merge to swap.
    send_batch('{32'sd7, -32'sd3, 32'sd7, 32'sd7, -32'sd3, VAL_MIN, VAL_MIN});
    send_batch('{32'sd5, 32'sd4, 32'sd3, 32'sd2, 32'sd1, 32'sd0});
    send_batch('{VAL_MAX, VAL_MIN});

    // Random batches: mostly short, and one that overflows the buffer so that the
    // closing item arrives while the buffer is full.
    batch_idx = 0;
    while (items_sent < TOTAL_ITEMS || batch_idx <= 3) begin
      if (batch_idx == 3)
        len = DEPTH + $urandom_range(1, 3);
      else if ($urandom_range(0, 3) == 0)
        len = $urandom_range(7, 16);
      else
        len = $urandom_range(1, 6);
      for (int n = 0; n < len; n++) send_item(pick_value(), n == len - 1);
      batch_idx++;
    end
    in_valid <= 1'b0;

    // Drain: wait for every queued result, then linger to catch stray extra results.
    while (sorter.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sorter.mismatches == 0 && sorter.pending() == 0) begin
      $display("PASS merge_sorter_unit");
    end else begin
      $display("FAIL merge_sorter_unit");
    end
    $finish;
  end

  // Receiver: check each result transaction, toggle ready at random outside a steady
  // window, and once, mid-run, hold off long enough that the block stalls its input.
  initial begin
    bit held_off;
    bit steady;
    held_off = 1'b0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready)
        sorter.check_result(sorted_value, last_out, overflow);
      if (!held_off && out_valid && out_ready && !last_out && sorter.results_checked >= 5) begin
        // Hold off while the run still has results inside the block.
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      steady = (sorter.results_checked >= 70 && sorter.results_checked < 140);
      out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Watchdog: end the run if neither channel moves a transaction for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("FAIL merge_sorter_unit");
        $finish;
      end
    end
  end

endmodule

>>> filelist.f
src/msort_pkg.sv
src/msort_ram.sv
src/msort_merge.sv
src/merge_sorter_unit.sv
tb/tb_merge_sorter_unit.sv
